// ===== sv/ssmt_pkg.sv =====
// ssmt_pkg: shared constants and types for the superset minimum table
// used by ssmt_ram users and superset_min_table_core; no dependencies
package ssmt_pkg;

    localparam int CATEGORY_BITS = 12;
    localparam int VALUE_WIDTH   = 32;
    localparam int HIGH_BITS     = CATEGORY_BITS / 2;
    localparam int LOW_BITS      = CATEGORY_BITS - HIGH_BITS;
    localparam int TABLE_DEPTH   = 1 << CATEGORY_BITS;

    localparam logic [VALUE_WIDTH-1:0] EMPTY_MARK = {VALUE_WIDTH{1'b1}};

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_WAIT,
        ST_DONE
    } state_t;

endpackage

// ===== sv/superset_min_table_core.sv =====
// superset_min_table_core: top level of the superset minimum table
// depends on ssmt_pkg and ssmt_ram
//
// Each beat on the input carries a command, a category mask and a value. An insert
// lowers the running minimum of every cell whose high half is a subset of the item's
// high half, at the item's low half; a query scans the cells at its own high half whose
// low half is a superset of its low half and returns one beat with the minimum and a
// found flag. Inserts return nothing. All cells live in one RAM with one read port and
// one write port, visited one cell per cycle in a read-then-write-back pipeline: an
// insert visits 2^k cells with k the number of set bits in the high half, a query
// 2^z cells with z the number of clear bits in the low half. After reset the block
// runs a clearing pass over all 4096 cells, one cell a cycle, before it accepts its
// first beat. Only one item is in flight; a finished query result waits in the
// output register while the next item is taken.
module superset_min_table_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  command,
    input  logic [ssmt_pkg::CATEGORY_BITS-1:0]    category,
    input  logic [ssmt_pkg::VALUE_WIDTH-1:0]      value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [ssmt_pkg::VALUE_WIDTH-1:0]      min_value,
    output logic                                  found
);

    localparam int CB = ssmt_pkg::CATEGORY_BITS;
    localparam int VW = ssmt_pkg::VALUE_WIDTH;
    localparam int HB = ssmt_pkg::HIGH_BITS;
    localparam int LB = ssmt_pkg::LOW_BITS;

    ssmt_pkg::state_t state_reg, state_next;

    logic [CB-1:0] clear_cnt_reg, clear_cnt_next;
    logic          cmd_reg, cmd_next;
    logic [HB-1:0] hi_reg, hi_next;
    logic [LB-1:0] lo_reg, lo_next;
    logic [VW-1:0] val_reg, val_next;
    logic [LB-1:0] s_reg, s_next;
    logic [LB-1:0] mask_reg, mask_next;
    logic          p_vld_reg, p_vld_next;
    logic [CB-1:0] p_idx_reg, p_idx_next;
    logic [VW-1:0] best_reg, best_next;
    logic          out_valid_reg, out_valid_next;
    logic [VW-1:0] min_value_reg, min_value_next;
    logic          found_reg, found_next;

    logic          in_fire;
    logic          out_load;
    logic [CB-1:0] cur_idx;
    logic          rd_en;
    logic [CB-1:0] rd_addr;
    logic [VW-1:0] rd_data;
    logic          wr_en;
    logic [CB-1:0] wr_addr;
    logic [VW-1:0] wr_data;

    assign in_fire  = in_valid && in_ready;
    assign out_load = (state_reg == ssmt_pkg::ST_DONE) && (!out_valid_reg || out_ready);

    assign cur_idx = (cmd_reg == ssmt_pkg::CMD_INSERT) ? {s_reg[HB-1:0], lo_reg}
                                                       : {hi_reg, lo_reg | s_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ssmt_pkg::ST_CLEAR:
            begin
                if (clear_cnt_reg == CB'(ssmt_pkg::TABLE_DEPTH - 1))
                begin
                    state_next = ssmt_pkg::ST_IDLE;
                end
            end
            ssmt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ssmt_pkg::ST_RUN;
                end
            end
            ssmt_pkg::ST_RUN:
            begin
                if (s_reg == '0)
                begin
                    state_next = ssmt_pkg::ST_WAIT;
                end
            end
            ssmt_pkg::ST_WAIT:
            begin
                state_next = (cmd_reg == ssmt_pkg::CMD_QUERY) ? ssmt_pkg::ST_DONE
                                                              : ssmt_pkg::ST_IDLE;
            end
            ssmt_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ssmt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ssmt_pkg::ST_CLEAR;
            end
        endcase
    end

    // handshake and ram control
    always_comb
    begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = cur_idx;
        wr_en    = 1'b0;
        wr_addr  = p_idx_reg;
        wr_data  = val_reg;
        unique case (state_reg)
            ssmt_pkg::ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clear_cnt_reg;
                wr_data = ssmt_pkg::EMPTY_MARK;
            end
            ssmt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ssmt_pkg::ST_RUN:
            begin
                rd_en = 1'b1;
                wr_en = p_vld_reg && (cmd_reg == ssmt_pkg::CMD_INSERT) && (rd_data > val_reg);
            end
            ssmt_pkg::ST_WAIT:
            begin
                wr_en = p_vld_reg && (cmd_reg == ssmt_pkg::CMD_INSERT) && (rd_data > val_reg);
            end
            ssmt_pkg::ST_DONE:
            begin
                wr_en = 1'b0;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        clear_cnt_next = clear_cnt_reg;
        cmd_next       = cmd_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        val_next       = val_reg;
        s_next         = s_reg;
        mask_next      = mask_reg;
        best_next      = best_reg;
        p_vld_next     = (state_reg == ssmt_pkg::ST_RUN);
        p_idx_next     = cur_idx;
        min_value_next = min_value_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg;

        if (state_reg == ssmt_pkg::ST_CLEAR)
        begin
            clear_cnt_next = clear_cnt_reg + CB'(1);
        end

        if (in_fire)
        begin
            cmd_next  = command;
            hi_next   = category[CB-1:LB];
            lo_next   = category[LB-1:0];
            val_next  = value;
            best_next = ssmt_pkg::EMPTY_MARK;
            if (command == ssmt_pkg::CMD_INSERT)
            begin
                s_next    = LB'(category[CB-1:LB]);
                mask_next = LB'(category[CB-1:LB]);
            end
            else
            begin
                s_next    = ~category[LB-1:0];
                mask_next = ~category[LB-1:0];
            end
        end
        else if (state_reg == ssmt_pkg::ST_RUN)
        begin
            s_next = (s_reg - LB'(1)) & mask_reg;
        end

        if (p_vld_reg && (cmd_reg == ssmt_pkg::CMD_QUERY) && (rd_data < best_reg))
        begin
            best_next = rd_data;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
            min_value_next = best_reg;
            found_next     = (best_reg != ssmt_pkg::EMPTY_MARK);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ssmt_pkg::ST_CLEAR;
            clear_cnt_reg <= '0;
            p_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_cnt_reg <= clear_cnt_next;
            p_vld_reg     <= p_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        hi_reg        <= hi_next;
        lo_reg        <= lo_next;
        val_reg       <= val_next;
        s_reg         <= s_next;
        mask_reg      <= mask_next;
        p_idx_reg     <= p_idx_next;
        best_reg      <= best_next;
        min_value_reg <= min_value_next;
        found_reg     <= found_next;
    end

    ssmt_ram #(
        .WIDTH (VW),
        .DEPTH (ssmt_pkg::TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_valid = out_valid_reg;
    assign min_value = min_value_reg;
    assign found     = found_reg;

    // no beat taken before the clearing pass ends
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ssmt_pkg::ST_CLEAR) |-> !in_ready)
        else $error("input accepted during clearing pass");

    // write-back never hits the cell being read in the same cycle
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write to the same cell");

    // queries never modify the table
    a_query_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && (state_reg != ssmt_pkg::ST_CLEAR)) |-> (cmd_reg == ssmt_pkg::CMD_INSERT))
        else $error("table written during a query");

    // a pipelined read result follows a read cycle
    a_pipe_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        p_vld_reg |-> $past(rd_en))
        else $error("read data consumed without a read");

    // a loaded result reports found consistently with its value
    a_found_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (found_reg == (min_value_reg != ssmt_pkg::EMPTY_MARK)))
        else $error("found flag disagrees with result value");

endmodule

// ===== sv/ssmt_ram.sv =====
// ssmt_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module ssmt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
